FILE: design/assert_macros.svh
// Assertion helpers shared by the top module and the divider cell.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PSSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Plain invariant, checked outside reset.
`define PSSC_ASSERT_HOLD(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

`endif

FILE: design/pssc_pkg.sv
`timescale 1ns / 1ps
package pssc_pkg;

    localparam int MIN_COV_W  = 18;
    localparam int MIN_CNT_W  = 16;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CONF_W     = 17;

    typedef enum logic [2:0] {
        BASE_A = 3'd0,
        BASE_C = 3'd1,
        BASE_G = 3'd2,
        BASE_T = 3'd3,
        BASE_N = 3'd4
    } t_base;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_COV = 2'd0,
        CFG_MAX_COV = 2'd1,
        CFG_MIN_CNT = 2'd2,
        CFG_TOL_DEL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [MIN_COV_W-1:0] min_cov;
        logic [MIN_COV_W-1:0] max_cov;
        logic [MIN_CNT_W-1:0] min_cnt;
        logic                 tol_del;
    } t_cfg;

    typedef struct packed {
        logic  covered;
        logic  snp;
        logic  biallelic;
        logic  ignored;
        t_base base;
    } t_site_flags;

endpackage

FILE: design/pileup_site_status_consensus.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// site      in         start & !busy           i_count_a/c/g/t/del
// result    out        o_valid, one cycle      o_covered .. o_confidence
// config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// One site enters every cycle; busy stays low.
// Each accepted site passes through two front stages (sum and largest count,
// then coverage and flags), one cell per quotient bit of the 17-bit
// confidence, then the output register.
// Synchronous active-low reset clears the valid bits and the configuration; the data registers are not reset.
// The receiver cannot stall, so nothing is held back.
`include "assert_macros.svh"
module pileup_site_status_consensus
    import pssc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COUNT_BITS-1:0] i_count_a,
    input  logic [COUNT_BITS-1:0] i_count_c,
    input  logic [COUNT_BITS-1:0] i_count_g,
    input  logic [COUNT_BITS-1:0] i_count_t,
    input  logic [COUNT_BITS-1:0] i_count_del,
    output logic                  o_valid,
    output logic                  o_covered,
    output logic                  o_snp,
    output logic                  o_biallelic,
    output logic                  o_ignored,
    output logic [2:0]            o_consensus_base,
    output logic [CONF_W-1:0]     o_confidence,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = COUNT_BITS + 2;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_COV: r_cfg.min_cov <= i_cfg_data[MIN_COV_W-1:0];
                CFG_MAX_COV: r_cfg.max_cov <= i_cfg_data[MIN_COV_W-1:0];
                CFG_MIN_CNT: r_cfg.min_cnt <= i_cfg_data[MIN_CNT_W-1:0];
                CFG_TOL_DEL: r_cfg.tol_del <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic              w_valid [CONF_W+1];
    t_site_flags       w_flags [CONF_W+1];
    logic [SUM_W-1:0]  w_sum   [CONF_W+1];
    logic [SUM_W-1:0]  w_rem   [CONF_W+1];
    logic [CONF_W-1:0] w_quo   [CONF_W+1];

    pssc_front #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (start && !busy),
        .i_count_a   (i_count_a),
        .i_count_c   (i_count_c),
        .i_count_g   (i_count_g),
        .i_count_t   (i_count_t),
        .i_count_del (i_count_del),
        .o_valid     (w_valid[0]),
        .o_flags     (w_flags[0]),
        .o_sum       (w_sum[0]),
        .o_max       (w_rem[0])
    );

    assign w_quo[0] = '0;

    for (genvar k = 0; k < CONF_W; k++) begin : g_cell
        pssc_div_cell #(
            .SUM_W (SUM_W),
            .FIRST (k == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_flags (w_flags[k]),
            .i_sum   (w_sum[k]),
            .i_rem   (w_rem[k]),
            .i_quo   (w_quo[k]),
            .o_valid (w_valid[k+1]),
            .o_flags (w_flags[k+1]),
            .o_sum   (w_sum[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_quo   (w_quo[k+1])
        );
    end

    logic              r_valid;
    t_site_flags       r_flags;
    logic [CONF_W-1:0] r_conf;

    // drop the quotient of a site that is not covered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_valid[CONF_W];
        end
        r_flags <= w_flags[CONF_W];
        r_conf  <= w_flags[CONF_W].covered ? w_quo[CONF_W] : '0;
    end

    assign o_valid          = r_valid;
    assign o_covered        = r_flags.covered;
    assign o_snp            = r_flags.snp;
    assign o_biallelic      = r_flags.biallelic;
    assign o_ignored        = r_flags.ignored;
    assign o_consensus_base = r_flags.base;
    assign o_confidence     = r_conf;

    `PSSC_ASSERT_IMPL(a_snp_needs_cover, i_clk, i_rst_n, o_valid && o_snp, o_covered && !o_ignored)
    `PSSC_ASSERT_IMPL(a_bi_needs_snp, i_clk, i_rst_n, o_valid && o_biallelic, o_snp)
    `PSSC_ASSERT_IMPL(a_cover_base, i_clk, i_rst_n, o_valid, o_covered == (o_consensus_base != BASE_N))
    `PSSC_ASSERT_IMPL(a_conf_range, i_clk, i_rst_n, o_valid && o_covered, (o_confidence != '0) && (o_confidence <= 17'h10000))

endmodule

FILE: design/pssc_front.sv
`timescale 1ns / 1ps
module pssc_front
    import pssc_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int SUM_W      = COUNT_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    input  logic [COUNT_BITS-1:0] i_count_a,
    input  logic [COUNT_BITS-1:0] i_count_c,
    input  logic [COUNT_BITS-1:0] i_count_g,
    input  logic [COUNT_BITS-1:0] i_count_t,
    input  logic [COUNT_BITS-1:0] i_count_del,
    output logic                  o_valid,
    output t_site_flags           o_flags,
    output logic [SUM_W-1:0]      o_sum,
    output logic [SUM_W-1:0]      o_max
);

    localparam int CMP_W = (COUNT_BITS > MIN_CNT_W) ? COUNT_BITS : MIN_CNT_W;
    localparam int COV_W = (SUM_W > MIN_COV_W) ? SUM_W : MIN_COV_W;

    // stage A: sum, first largest count, allele and deletion tests
    logic [COUNT_BITS-1:0] w_cnt [4];
    logic [3:0]            w_pass;
    logic                  w_del_pass;
    logic [COUNT_BITS-1:0] w_max01, w_max23, w_max;
    t_base                 w_base01, w_base23, w_base;
    logic [SUM_W-1:0]      w_sum;

    logic                  r_a_valid;
    logic [SUM_W-1:0]      r_a_sum;
    logic [COUNT_BITS-1:0] r_a_max;
    t_base                 r_a_base;
    logic [3:0]            r_a_pass;
    logic                  r_a_del;

    assign w_cnt[0] = i_count_a;
    assign w_cnt[1] = i_count_c;
    assign w_cnt[2] = i_count_g;
    assign w_cnt[3] = i_count_t;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_pass[k] = (w_cnt[k] != '0) && (CMP_W'(w_cnt[k]) >= CMP_W'(i_cfg.min_cnt));
        end
        w_del_pass = (i_count_del != '0) && (CMP_W'(i_count_del) >= CMP_W'(i_cfg.min_cnt));
        w_sum = SUM_W'(i_count_a) + SUM_W'(i_count_c) + SUM_W'(i_count_g)
              + SUM_W'(i_count_t);
        // strict compares keep the earlier base on a tie
        if (i_count_c > i_count_a) begin
            w_max01  = i_count_c;
            w_base01 = BASE_C;
        end else begin
            w_max01  = i_count_a;
            w_base01 = BASE_A;
        end
        if (i_count_t > i_count_g) begin
            w_max23  = i_count_t;
            w_base23 = BASE_T;
        end else begin
            w_max23  = i_count_g;
            w_base23 = BASE_G;
        end
        if (w_max23 > w_max01) begin
            w_max  = w_max23;
            w_base = w_base23;
        end else begin
            w_max  = w_max01;
            w_base = w_base01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_sum  <= w_sum;
        r_a_max  <= w_max;
        r_a_base <= w_base;
        r_a_pass <= w_pass;
        r_a_del  <= w_del_pass;
    end

    // stage B: coverage limits and flag resolution
    logic        w_cov, w_ign, w_covered;
    logic [2:0]  w_alleles;
    t_site_flags n_flags;
    logic        r_b_valid;
    t_site_flags r_b_flags;
    logic [SUM_W-1:0] r_b_sum, r_b_max;

    always_comb begin
        w_alleles = 3'(r_a_pass[0]) + 3'(r_a_pass[1]) + 3'(r_a_pass[2]) + 3'(r_a_pass[3]);
        w_cov = (r_a_sum != '0)
              && (COV_W'(r_a_sum) >= COV_W'(i_cfg.min_cov))
              && ((i_cfg.max_cov == '0) || (COV_W'(r_a_sum) <= COV_W'(i_cfg.max_cov)));
        w_ign     = w_cov && r_a_del && !i_cfg.tol_del;
        w_covered = w_cov && !w_ign;
        n_flags.covered   = w_covered;
        n_flags.snp       = w_covered && (w_alleles >= 3'd2);
        n_flags.biallelic = w_covered && (w_alleles == 3'd2);
        n_flags.ignored   = w_ign;
        n_flags.base      = w_covered ? r_a_base : BASE_N;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_flags <= n_flags;
        r_b_sum   <= r_a_sum;
        r_b_max   <= SUM_W'(r_a_max);
    end

    assign o_valid = r_b_valid;
    assign o_flags = r_b_flags;
    assign o_sum   = r_b_sum;
    assign o_max   = r_b_max;

endmodule

FILE: design/pssc_div_cell.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pssc_div_cell
    import pssc_pkg::*;
#(
    parameter int SUM_W = 18,
    parameter bit FIRST = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_site_flags       i_flags,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic [SUM_W-1:0]  i_rem,
    input  logic [CONF_W-1:0] i_quo,
    output logic              o_valid,
    output t_site_flags       o_flags,
    output logic [SUM_W-1:0]  o_sum,
    output logic [SUM_W-1:0]  o_rem,
    output logic [CONF_W-1:0] o_quo
);

    logic [SUM_W:0]    w_shift, w_diff;
    logic              w_ge;
    logic [SUM_W-1:0]  n_rem;
    logic [CONF_W-1:0] n_quo;

    logic              r_valid;
    t_site_flags       r_flags;
    logic [SUM_W-1:0]  r_sum, r_rem;
    logic [CONF_W-1:0] r_quo;

    // one restoring step: the first cell yields the integer bit, no shift
    always_comb begin
        w_shift = FIRST ? {1'b0, i_rem} : {i_rem, 1'b0};
        w_ge    = w_shift >= {1'b0, i_sum};
        w_diff  = w_shift - {1'b0, i_sum};
        n_rem   = w_ge ? w_diff[SUM_W-1:0] : w_shift[SUM_W-1:0];
        n_quo   = {i_quo[CONF_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_flags <= i_flags;
        r_sum   <= i_sum;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_sum   = r_sum;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

    // a covered site never has a zero divisor, and the partial remainder stays below it
    `PSSC_ASSERT_IMPL(a_rem_below_sum, i_clk, i_rst_n, r_valid && r_flags.covered, r_rem < r_sum)

endmodule
